>>> hdl/gwwb_pkg.sv
// ----------------------------------------------------------------------------
// gwwb_pkg
// Shared types and constants of the gray-world white balance core: the
// controller states and the command and status groups between controller
// and datapath.
// ----------------------------------------------------------------------------
package gwwb_pkg;

  // integer bits of a gain, fixed by the Q8.f gain format
  localparam int unsigned GAIN_INT_BITS = 8;

  // width of the sample depth register and its value after reset
  localparam int unsigned DEPTH_W = 5;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

  // controller states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_STORE
  } gwwb_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic run;         // pixel stream may move
    logic div_start;   // load divider with green sum and selected sum
    logic div_step;    // one quotient bit
    logic sel_blue;    // divider works on blue channel
    logic gain_write;  // store divider result in selected gain
    logic sum_clear;   // clear the three channel sums
  } gwwb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_accepted;  // last pixel of accumulate pass taken
    logic div_last;       // divider works on its final bit
  } gwwb_status_t;

endpackage

>>> hdl/gwwb_div.sv
// ----------------------------------------------------------------------------
// gwwb_div
// Restoring divider for one gain: num/den in unsigned Q8.f, truncated,
// one quotient bit per step. Zero operands give 1.0, overflow saturates.
// ----------------------------------------------------------------------------
module gwwb_div
  import gwwb_pkg::*;
#(
  parameter int unsigned SUM_W          = 40,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic                                    step_i,
  input  logic [SUM_W-1:0]                        num_i,
  input  logic [SUM_W-1:0]                        den_i,
  output logic [GAIN_INT_BITS+GAIN_FRAC_BITS-1:0] quot_o,
  output logic                                    last_o
);

  localparam int unsigned GAIN_W = GAIN_INT_BITS + GAIN_FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(GAIN_W);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [GAIN_W-1:0] low_q, low_d;
  logic [GAIN_W-1:0] quot_q, quot_d;
  logic              special_q, special_d;
  logic [GAIN_W-1:0] special_val_q, special_val_d;
  logic [SUM_W:0]    trial;
  logic              fits;
  logic              zero_op;
  logic              saturate;

  // operand checks at load time
  assign zero_op  = (num_i == '0) || (den_i == '0);
  assign saturate = {{GAIN_INT_BITS{1'b0}}, num_i} >= {den_i, {GAIN_INT_BITS{1'b0}}};

  // trial subtract: the divisor is held by the sum register during the run
  assign trial = {rem_q, low_q[GAIN_W-1]};
  assign fits  = trial >= {1'b0, den_i};

  // next values of the iteration
  always_comb begin
    cnt_d         = cnt_q;
    rem_d         = rem_q;
    low_d         = low_q;
    quot_d        = quot_q;
    special_d     = special_q;
    special_val_d = special_val_q;
    if (start_i) begin
      cnt_d         = CNT_W'(GAIN_W - 1);
      rem_d         = SUM_W'(num_i >> GAIN_INT_BITS);
      low_d         = GAIN_W'(num_i[GAIN_INT_BITS-1:0]) << GAIN_FRAC_BITS;
      quot_d        = '0;
      special_d     = zero_op || saturate;
      special_val_d = zero_op ? GAIN_ONE : GAIN_MAX;
    end else if (step_i) begin
      cnt_d  = cnt_q - CNT_W'(1);
      rem_d  = fits ? SUM_W'(trial - {1'b0, den_i}) : SUM_W'(trial);
      low_d  = low_q << 1;
      quot_d = {quot_q[GAIN_W-2:0], fits};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // remainder, dividend bits and quotient
  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    low_q         <= low_d;
    quot_q        <= quot_d;
    special_q     <= special_d;
    special_val_q <= special_val_d;
  end

  assign last_o = (cnt_q == '0);
  assign quot_o = special_q ? special_val_q : quot_q;

endmodule

>>> hdl/gwwb_dp.sv
// ----------------------------------------------------------------------------
// gwwb_dp
// Datapath: channel sums, gain registers, gain divider, and the two-stage
// scaling pipeline (multiply, then round and clamp) with its output register.
// ----------------------------------------------------------------------------
module gwwb_dp
  import gwwb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS      = 16,
  parameter int unsigned PIXEL_COUNT_BITS = 24,
  parameter int unsigned GAIN_FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [15:0]        red_i,
  input  logic [15:0]        green_i,
  input  logic [15:0]        blue_i,
  input  logic               last_i,
  // pixel output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  // sample depth register
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  // controller
  input  gwwb_cmd_t          cmd_i,
  output gwwb_status_t       status_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + PIXEL_COUNT_BITS;
  localparam int unsigned GAIN_W = GAIN_INT_BITS + GAIN_FRAC_BITS;
  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int unsigned SCL_W  = SAMPLE_BITS + GAIN_INT_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

  logic [SAMPLE_BITS-1:0] red_smp, green_smp, blue_smp;
  logic                   accept;
  logic                   p1_en, out_en;

  logic [DEPTH_W-1:0]     depth_q;
  logic [DEPTH_W-1:0]     depth_eff;
  logic [SAMPLE_BITS-1:0] max_val;

  logic [SUM_W-1:0]       red_sum_q, green_sum_q, blue_sum_q;
  logic [GAIN_W-1:0]      red_gain_q, blue_gain_q;
  logic [GAIN_W-1:0]      div_quot;
  logic                   div_last;

  logic                   p1_valid_q;
  logic [PROD_W-1:0]      red_prod_q, blue_prod_q;
  logic [SAMPLE_BITS-1:0] green_p1_q;

  logic [PROD_W-1:0]      red_round, blue_round;
  logic [SCL_W-1:0]       red_scl, blue_scl;
  logic [SAMPLE_BITS-1:0] red_clamp, green_clamp, blue_clamp;

  logic                   out_valid_q;
  logic [15:0]            red_out_q, green_out_q, blue_out_q;

  // only the low sample bits take part
  assign red_smp   = red_i[SAMPLE_BITS-1:0];
  assign green_smp = green_i[SAMPLE_BITS-1:0];
  assign blue_smp  = blue_i[SAMPLE_BITS-1:0];

  // pipeline flow control
  assign out_en     = !out_valid_q || out_ready_i;
  assign p1_en      = !p1_valid_q || out_en;
  assign in_ready_o = cmd_i.run && p1_en;
  assign accept     = in_valid_i && in_ready_o;

  assign status_o.last_accepted = accept && !mode_i && last_i;
  assign status_o.div_last      = div_last;

  // sample depth register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      depth_q <= cfg_wdata_i;
    end
  end

  // effective depth and clamp value
  always_comb begin
    depth_eff = depth_q;
    if (depth_q == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (depth_q > DEPTH_W'(SAMPLE_BITS)) begin
      depth_eff = DEPTH_W'(SAMPLE_BITS);
    end
  end
  assign max_val = SAMPLE_ONES >> (DEPTH_W'(SAMPLE_BITS) - depth_eff);

  // channel sums, wrapping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else if (cmd_i.sum_clear) begin
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else if (accept && !mode_i) begin
      red_sum_q   <= red_sum_q + SUM_W'(red_smp);
      green_sum_q <= green_sum_q + SUM_W'(green_smp);
      blue_sum_q  <= blue_sum_q + SUM_W'(blue_smp);
    end
  end

  // shared gain divider, green sum over red or blue sum
  gwwb_div #(
    .SUM_W          (SUM_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .num_i   (green_sum_q),
    .den_i   (cmd_i.sel_blue ? blue_sum_q : red_sum_q),
    .quot_o  (div_quot),
    .last_o  (div_last)
  );

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_q  <= GAIN_ONE;
      blue_gain_q <= GAIN_ONE;
    end else if (cmd_i.gain_write) begin
      if (cmd_i.sel_blue) begin
        blue_gain_q <= div_quot;
      end else begin
        red_gain_q <= div_quot;
      end
    end
  end

  // stage one: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (p1_en) begin
      p1_valid_q <= accept && mode_i;
    end
  end

  // stage one: products with the gains in force at acceptance
  always_ff @(posedge clk_i) begin
    if (p1_en) begin
      red_prod_q  <= PROD_W'(red_smp) * PROD_W'(red_gain_q);
      blue_prod_q <= PROD_W'(blue_smp) * PROD_W'(blue_gain_q);
      green_p1_q  <= green_smp;
    end
  end

  // stage two: round half up and clamp
  assign red_round  = red_prod_q + HALF;
  assign blue_round = blue_prod_q + HALF;
  assign red_scl    = red_round[PROD_W-1:GAIN_FRAC_BITS];
  assign blue_scl   = blue_round[PROD_W-1:GAIN_FRAC_BITS];

  assign red_clamp   = (red_scl > SCL_W'(max_val)) ? max_val : red_scl[SAMPLE_BITS-1:0];
  assign blue_clamp  = (blue_scl > SCL_W'(max_val)) ? max_val : blue_scl[SAMPLE_BITS-1:0];
  assign green_clamp = (green_p1_q > max_val) ? max_val : green_p1_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      red_out_q   <= 16'(red_clamp);
      green_out_q <= 16'(green_clamp);
      blue_out_q  <= 16'(blue_clamp);
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_out_q;
  assign green_o     = green_out_q;
  assign blue_o      = blue_out_q;

  // sums are empty after a clear
  a_sum_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum_clear |=> (red_sum_q == '0) && (green_sum_q == '0) && (blue_sum_q == '0))
    else $error("channel sums not cleared");

  // an accepted apply pixel always reaches stage one
  a_apply_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i) |=> p1_valid_q)
    else $error("apply pixel lost at stage one");

endmodule

>>> hdl/gwwb_ctrl.sv
// ----------------------------------------------------------------------------
// gwwb_ctrl
// Controller: runs the pixel stream and, at the end of an accumulate pass,
// sequences the red then blue gain division and the clearing of the sums.
// ----------------------------------------------------------------------------
module gwwb_ctrl
  import gwwb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gwwb_status_t status_i,
  output gwwb_cmd_t    cmd_o
);

  gwwb_state_e state_q, state_d;
  logic        sel_q, sel_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    sel_d          = sel_q;
    cmd_o          = '0;
    cmd_o.sel_blue = sel_q;
    unique case (state_q)
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (status_i.last_accepted) begin
          sel_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.gain_write = 1'b1;
        if (sel_q) begin
          cmd_o.sum_clear = 1'b1;
          sel_d           = 1'b0;
          state_d         = ST_RUN;
        end else begin
          sel_d   = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // a gain is stored only right after the division finished
  a_store_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |-> ($past(state_q) == ST_DIV))
    else $error("gain stored without division");

  // frame end starts the gain computation
  a_last_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_i.last_accepted && (state_q == ST_RUN)) |=> (state_q == ST_LOAD) && !sel_q)
    else $error("frame end did not start red gain division");

endmodule

>>> hdl/gray_world_white_balance_core.sv
// An apply-mode pixel passes the stage-one register, then the output register.
// Throughput: one pixel per cycle in both modes while the output is taken and
// no gain is being computed. The pixel flagged last in accumulate mode stalls
// input for the red, then blue gain: load, one divider bit per cycle, store.
// Reset: sums cleared, both gains 1.0, sample depth 8, no result pending.
// ----------------------------------------------------------------------------
// gray_world_white_balance_core
// Gray-world white balance over an RGB pixel stream: accumulate pass builds
// channel sums and gains, apply pass scales red and blue by their gains.
// ----------------------------------------------------------------------------
module gray_world_white_balance_core
  import gwwb_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS      = 16,
  parameter int unsigned PIXEL_COUNT_BITS = 24,
  parameter int unsigned GAIN_FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel input
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // red_in, green_in, blue_in
  input  logic               s_tuser,   // mode
  input  logic               s_tlast,   // frame_last
  // pixel output
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [47:0]        m_tdata,   // red_out, green_out, blue_out
  // sample depth register
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i
);

  gwwb_cmd_t    cmd;
  gwwb_status_t status;

  // sequencing
  gwwb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // sums, gains and scaling
  gwwb_dp #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .mode_i      (s_tuser),
    .red_i       (s_tdata[15:0]),
    .green_i     (s_tdata[31:16]),
    .blue_i      (s_tdata[47:32]),
    .last_i      (s_tlast),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .red_o       (m_tdata[15:0]),
    .green_o     (m_tdata[31:16]),
    .blue_o      (m_tdata[47:32]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> sim/tb_gray_world_white_balance_core.sv
// ----------------------------------------------------------------------------
// tb_gray_world_white_balance_core
// Self-checking bench for the gray-world white balance core. Accumulate passes
// of random length and colour cast build the gains. Apply passes are checked
// pixel by pixel against a bit-exact software model of the sums, the gain
// divisions and the rounding and clamping. The run steps through several
// sample depths and three idle patterns on the input and output sides.
// ----------------------------------------------------------------------------
module tb_gray_world_white_balance_core;
  import gwwb_pkg::*;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned GAIN_W    = GAIN_INT_BITS + FRAC_W;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'h010000;
  localparam logic [GAIN_W-1:0] GAIN_TOP   = 24'hFFFFFF;

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  localparam int unsigned PIXEL_GOAL     = 650;
  localparam int unsigned DIV_SETTLE     = 64;   // two gain divisions plus margin
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam logic [DEPTH_W-1:0] DEPTH_PLAN [8] =
    '{5'd1, 5'd0, 5'd31, 5'd12, 5'd16, 5'd5, 5'd8, 5'd15};

  // --------------------------------------------------------------------------
  // expected pixel store with its own copy of the sums, gains and depth
  // --------------------------------------------------------------------------
  class balance_scoreboard;
    logic [SUM_W-1:0]   red_acc, green_acc, blue_acc;
    logic [GAIN_W-1:0]  red_gain, blue_gain;
    logic [DEPTH_W-1:0] depth;
    logic [47:0]        expected_rgb [$];
    int unsigned        mismatch_count, stray_count, checked_count;
    int unsigned        frames_closed, saturated_gains;

    function new();
      red_acc = '0;
      green_acc = '0;
      blue_acc = '0;
      red_gain = GAIN_UNITY;
      blue_gain = GAIN_UNITY;
      depth = DEPTH_RESET;
      mismatch_count = 0;
      stray_count = 0;
      checked_count = 0;
      frames_closed = 0;
      saturated_gains = 0;
    endfunction

    function int unsigned pending();
      return expected_rgb.size();
    endfunction

    // green over channel sum in Q8.16, truncated, saturating
    function logic [GAIN_W-1:0] gain_ratio(logic [SUM_W-1:0] num, logic [SUM_W-1:0] den);
      logic [63:0] q;
      if ({24'd0, num} >= ({24'd0, den} << GAIN_INT_BITS)) begin
        saturated_gains++;
        return GAIN_TOP;
      end
      q = ({24'd0, num} << FRAC_W) / {24'd0, den};
      return q[GAIN_W-1:0];
    endfunction

    // output ceiling from the depth register, depth held to 1..16
    function logic [SAMPLE_W-1:0] sample_ceiling();
      logic [31:0] d;
      logic [31:0] lim;
      d = depth;
      if (d < 1) d = 1;
      if (d > SAMPLE_W) d = SAMPLE_W;
      lim = (32'd1 << d) - 32'd1;
      return lim[SAMPLE_W-1:0];
    endfunction

    // multiply by gain, round half up, clamp
    function logic [SAMPLE_W-1:0] scale_sample(logic [SAMPLE_W-1:0] x,
                                               logic [GAIN_W-1:0] gain,
                                               logic [SAMPLE_W-1:0] ceil_v);
      logic [63:0] prod;
      prod = ({48'd0, x} * {40'd0, gain} + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      if (prod > {48'd0, ceil_v}) prod = {48'd0, ceil_v};
      return prod[SAMPLE_W-1:0];
    endfunction

    function void note_pixel(logic mode, logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                             logic [SAMPLE_W-1:0] b, logic last);
      logic [SAMPLE_W-1:0] ceil_v;
      if (mode == MODE_ACCUM) begin
        red_acc   = red_acc + r;
        green_acc = green_acc + g;
        blue_acc  = blue_acc + b;
        if (last) begin
          if (green_acc == '0) begin
            red_gain = GAIN_UNITY;
            blue_gain = GAIN_UNITY;
          end else begin
            red_gain  = (red_acc == '0) ? GAIN_UNITY : gain_ratio(green_acc, red_acc);
            blue_gain = (blue_acc == '0) ? GAIN_UNITY : gain_ratio(green_acc, blue_acc);
          end
          red_acc = '0;
          green_acc = '0;
          blue_acc = '0;
          frames_closed++;
        end
      end else begin
        ceil_v = sample_ceiling();
        expected_rgb.push_back({scale_sample(b, blue_gain, ceil_v),
                                (g > ceil_v) ? ceil_v : g,
                                scale_sample(r, red_gain, ceil_v)});
      end
    endfunction

    function void check_pixel(logic [47:0] got);
      logic [47:0] want;
      if (expected_rgb.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= 10)
          $display("%0t: unexpected output pixel r=%0d g=%0d b=%0d", $time,
                   got[15:0], got[31:16], got[47:32]);
        return;
      end
      want = expected_rgb.pop_front();
      checked_count++;
      if (want[15:0] != got[15:0] || want[31:16] != got[31:16] ||
          want[47:32] != got[47:32]) begin
        mismatch_count++;
        if (mismatch_count + stray_count <= 10)
          $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                   $time, want[15:0], want[31:16], want[47:32],
                   got[15:0], got[31:16], got[47:32]);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [47:0]        s_tdata = '0;
  logic               s_tuser = MODE_ACCUM;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [47:0]        m_tdata;
  logic               cfg_we_i = 1'b0;
  logic [DEPTH_W-1:0] cfg_wdata_i = DEPTH_RESET;

  always #4 clk_i = ~clk_i;

  gray_world_white_balance_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  balance_scoreboard sb = new();

  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 65;
  int unsigned pixels_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned depth_writes = 0;

  // output side back-pressure
  always @(posedge clk_i) begin
    m_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result checking and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_pixel(m_tdata);
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("[gray_world_white_balance_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_pixel(logic mode, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                            logic last);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tlast  <= last;
    s_tdata  <= {b, g, r};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_pixel(mode, r, g, b, last);
    pixels_sent++;
  endtask

  // hold input until every output pixel is back
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // depth is only changed once the core is idle and the gain divisions are done
  task automatic write_depth(logic [DEPTH_W-1:0] d);
    drain_outputs();
    repeat (DIV_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.depth = d;
    depth_writes++;
  endtask

  // pixel content by colour-cast style
  function automatic void make_pixel(int unsigned style, output logic [15:0] r,
                                     output logic [15:0] g, output logic [15:0] b);
    int unsigned base;
    base = $urandom_range(0, 65535);
    r = 16'($urandom_range(0, 65535));
    g = 16'($urandom_range(0, 65535));
    b = 16'($urandom_range(0, 65535));
    case (style)
      1: begin
        // strong cast: green dominates, gains spread up to saturation
        g = 16'(base);
        r = 16'(base >> $urandom_range(0, 10));
        b = 16'(base >> $urandom_range(0, 3));
      end
      2: begin
        r = 16'($urandom_range(0, 255));
        g = 16'($urandom_range(0, 255));
        b = 16'($urandom_range(0, 255));
      end
      3: begin
        // one channel dark
        case ($urandom_range(0, 2))
          0: r = '0;
          1: g = '0;
          default: b = '0;
        endcase
      end
      default: ;
    endcase
  endfunction

  // one statistics pass followed by an apply pass
  task automatic run_frame();
    int unsigned style, n_acc, n_apply;
    logic [15:0] r, g, b;
    logic        closes;
    style   = $urandom_range(0, 3);
    n_acc   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    n_apply = $urandom_range(4, 24);
    closes  = ($urandom_range(0, 9) != 0);   // some passes run on without a last pixel
    for (int unsigned i = 0; i < n_acc; i++) begin
      make_pixel(style, r, g, b);
      send_pixel(MODE_ACCUM, r, g, b, closes && (i == n_acc - 1));
    end
    for (int unsigned i = 0; i < n_apply; i++) begin
      make_pixel(($urandom_range(0, 1) == 0) ? 0 : style, r, g, b);
      send_pixel(MODE_APPLY, r, g, b, 1'($urandom_range(0, 1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned frame_idx;
    frame_idx = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // apply with reset gains, last flag ignored in apply mode
    send_pixel(MODE_APPLY, 16'd0, 16'd0, 16'd0, 1'b0);
    send_pixel(MODE_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(MODE_APPLY, 16'd200, 16'd300, 16'd255, 1'b1);
    // zero green sum keeps both gains at unity
    send_pixel(MODE_ACCUM, 16'd10, 16'd0, 16'd20, 1'b1);
    send_pixel(MODE_APPLY, 16'd100, 16'd100, 16'd100, 1'b0);
    // zero red sum gives unity red gain
    send_pixel(MODE_ACCUM, 16'd0, 16'd50, 16'd30, 1'b0);
    send_pixel(MODE_ACCUM, 16'd0, 16'd70, 16'd10, 1'b1);
    send_pixel(MODE_APPLY, 16'd50, 16'd50, 16'd50, 1'b0);
    // red gain saturates, blue gain exactly one
    send_pixel(MODE_ACCUM, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(MODE_APPLY, 16'd1, 16'd2, 16'd3, 1'b0);
    send_pixel(MODE_APPLY, 16'd0, 16'd0, 16'hFFFF, 1'b0);
    // ordinary pass then full depth
    send_pixel(MODE_ACCUM, 16'd100, 16'd200, 16'd300, 1'b0);
    send_pixel(MODE_ACCUM, 16'd123, 16'd456, 16'd789, 1'b1);
    send_pixel(MODE_APPLY, 16'd255, 16'd128, 16'd1, 1'b0);
    write_depth(5'd16);
    send_pixel(MODE_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(MODE_APPLY, 16'h8000, 16'h7FFF, 16'h5555, 1'b0);
    send_pixel(MODE_ACCUM, 16'h0001, 16'hFFFF, 16'h00FF, 1'b1);
    send_pixel(MODE_APPLY, 16'h00FF, 16'hAAAA, 16'h0100, 1'b0);

    // random frames across depths and idle patterns
    while (pixels_sent < PIXEL_GOAL) begin
      if (pixels_sent >= 2 * PIXEL_GOAL / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (pixels_sent >= PIXEL_GOAL / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 12;
      end
      if (frame_idx % 3 == 0)
        write_depth(DEPTH_PLAN[(frame_idx / 3) % 8]);
      else if ($urandom_range(0, 5) == 0)
        drain_outputs();
      run_frame();
      frame_idx++;
    end

    // wait for the tail
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d pixels, %0d outputs checked, %0d passes closed, %0d saturated gains",
             pixels_sent, sb.checked_count, sb.frames_closed, sb.saturated_gains);
    $display("%0d depth writes, %0d mismatches, %0d unexpected, %0d outstanding",
             depth_writes, sb.mismatch_count, sb.stray_count, sb.pending());
    if (sb.mismatch_count == 0 && sb.stray_count == 0 && sb.pending() == 0)
      $display("[gray_world_white_balance_core] OK");
    else
      $display("[gray_world_white_balance_core] ERROR");
    $finish;
  end

endmodule
